### hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes of the scheduled timer table
// Beat layouts, op/result codes and the command queue entry.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Op codes of an input beat
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SCHED  = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_FIRED     = 3'd0;
  localparam logic [2:0] KIND_TICK_DONE = 3'd1;
  localparam logic [2:0] KIND_SCHEDULED = 3'd2;
  localparam logic [2:0] KIND_CANCELLED = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  // Result status
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DUR   = 2'd2;
  localparam logic [1:0] STATUS_SLOT_EMPTY = 2'd3;

  localparam int            DeltaW      = 20;
  localparam int            PeriodW     = 32;
  localparam int            ElapsedW    = 33;
  localparam logic [32:0]   ELAPSED_MAX = 33'h1_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         op;
    logic               timers_active;
    logic [DeltaW-1:0]  delta_us;
    logic [2:0]         slot;
    logic [PeriodW-1:0] duration;
    logic               repeat_req;
    logic               in_frames;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot_out;
    logic [1:0] status;
    logic       last;
  } res_t;

  // Command classes decided by the front end
  typedef enum logic [2:0] {
    CMD_TICK_HOLD  = 3'd0,
    CMD_TICK_RUN   = 3'd1,
    CMD_SCHED      = 3'd2,
    CMD_SCHED_ZERO = 3'd3,
    CMD_CANCEL     = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e               kind;
    logic [DeltaW-1:0]  delta_us;
    logic [2:0]         slot;
    logic [PeriodW-1:0] duration;
    logic               repeat_req;
    logic               in_frames;
  } cmd_t;

  // Front to back: head of the command queue
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fb_t;

endpackage

### hdl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front: command intake
// Classifies input beats and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module stt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  stt_pkg::in_t  cmd_i,
  output logic          busy_o,
  output stt_pkg::fb_t  fb_o,
  input  logic          pop_i
);

  stt_pkg::cmd_t q_mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  stt_pkg::cmd_t cls;

  // op 3 is dropped here and never reaches the queue
  always_comb begin
    cls            = '0;
    cls.delta_us   = cmd_i.delta_us;
    cls.slot       = cmd_i.slot;
    cls.duration   = cmd_i.duration;
    cls.repeat_req = cmd_i.repeat_req;
    cls.in_frames  = cmd_i.in_frames;
    unique case (cmd_i.op)
      stt_pkg::OP_TICK:   cls.kind = cmd_i.timers_active ? stt_pkg::CMD_TICK_RUN
                                                         : stt_pkg::CMD_TICK_HOLD;
      stt_pkg::OP_SCHED:  cls.kind = (cmd_i.duration == '0) ? stt_pkg::CMD_SCHED_ZERO
                                                            : stt_pkg::CMD_SCHED;
      stt_pkg::OP_CANCEL: cls.kind = stt_pkg::CMD_CANCEL;
      default:            cls.kind = stt_pkg::CMD_TICK_HOLD;
    endcase
  end

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o && (cmd_i.op != stt_pkg::OP_NONE);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  assign fb_o.valid = (cnt_q != 2'd0);
  assign fb_o.cmd   = q_mem_q[rd_ptr_q];

endmodule

### hdl/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back: timer table executor
// Runs queued commands against the slot table and emits at most one result per cycle.
// ----------------------------------------------------------------------------
module stt_back #(
  parameter int SLOTS      = 8,
  parameter int FIRE_LIMIT = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  stt_pkg::fb_t  fb_i,
  output logic          pop_o,
  output logic          idle_o,
  output logic          res_valid_o,
  output stt_pkg::res_t res_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FW = $clog2(FIRE_LIMIT + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_FIRE = 5'b01000,
    ST_WB   = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic                          done_q, done_d;   // tick-done still owed
  logic [IW-1:0]                 idx_q, idx_d;
  logic [stt_pkg::DeltaW-1:0]    delta_q, delta_d;
  logic [stt_pkg::ElapsedW-1:0]  e_q, e_d;
  logic [FW-1:0]                 fires_q, fires_d;
  logic [SLOTS-1:0]              valid_q, valid_d;
  logic [SLOTS-1:0]              rep_q, rep_d;
  logic [SLOTS-1:0]              frm_q, frm_d;
  logic                          out_valid_q, out_valid_d;
  stt_pkg::res_t                 out_q, out_d;

  // slot storage
  logic                          per_we, el_we;
  logic [IW-1:0]                 wr_idx;
  logic [stt_pkg::PeriodW-1:0]   per_wdata, per_rdata;
  logic [stt_pkg::ElapsedW-1:0]  el_wdata, el_rdata;

  logic [IW-1:0]                 free_idx;
  logic                          free_found;
  logic [IW-1:0]                 cidx;
  logic                          c_ok;
  logic [stt_pkg::ElapsedW:0]    sum;
  logic                          is_last_idx;
  logic                          can_fire;

  stt_ram #(.WIDTH(stt_pkg::PeriodW), .DEPTH(SLOTS)) u_period (
    .clk_i   (clk_i),
    .we_i    (per_we),
    .waddr_i (wr_idx),
    .wdata_i (per_wdata),
    .raddr_i (idx_q),
    .rdata_o (per_rdata)
  );

  stt_ram #(.WIDTH(stt_pkg::ElapsedW), .DEPTH(SLOTS)) u_elapsed (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (wr_idx),
    .wdata_i (el_wdata),
    .raddr_i (idx_q),
    .rdata_o (el_rdata)
  );

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = IW'(i);
        free_found = 1'b1;
      end
    end
  end

  assign cidx        = IW'(fb_i.cmd.slot);
  assign c_ok        = (32'(fb_i.cmd.slot) < 32'(SLOTS)) && valid_q[cidx];
  assign is_last_idx = (idx_q == IW'(SLOTS - 1));
  assign sum         = {1'b0, el_rdata}
                     + (frm_q[idx_q] ? (stt_pkg::ElapsedW + 1)'(1)
                                     : (stt_pkg::ElapsedW + 1)'(delta_q));
  assign can_fire    = (e_q >= {1'b0, per_rdata}) && (fires_q < FW'(FIRE_LIMIT));

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    idx_d       = idx_q;
    delta_d     = delta_q;
    e_d         = e_q;
    fires_d     = fires_q;
    valid_d     = valid_q;
    rep_d       = rep_q;
    frm_d       = frm_q;
    out_valid_d = 1'b0;
    out_d       = out_q;
    pop_o       = 1'b0;
    per_we      = 1'b0;
    el_we       = 1'b0;
    wr_idx      = idx_q;
    per_wdata   = fb_i.cmd.duration;
    el_wdata    = e_q;

    unique case (state_q)
      ST_IDLE: begin
        if (done_q) begin
          out_valid_d = 1'b1;
          out_d       = '{stt_pkg::KIND_TICK_DONE, 3'd0, stt_pkg::STATUS_OK, 1'b1};
          done_d      = 1'b0;
        end else if (fb_i.valid) begin
          pop_o = 1'b1;
          unique case (fb_i.cmd.kind)
            stt_pkg::CMD_TICK_RUN: begin
              delta_d = fb_i.cmd.delta_us;
              idx_d   = '0;
              state_d = ST_SCAN;
            end
            stt_pkg::CMD_SCHED_ZERO: begin
              out_valid_d = 1'b1;
              out_d = '{stt_pkg::KIND_ERROR, 3'd0, stt_pkg::STATUS_ZERO_DUR, 1'b1};
            end
            stt_pkg::CMD_SCHED: begin
              out_valid_d = 1'b1;
              if (free_found) begin
                valid_d[free_idx] = 1'b1;
                rep_d[free_idx]   = fb_i.cmd.repeat_req;
                frm_d[free_idx]   = fb_i.cmd.in_frames;
                per_we            = 1'b1;
                el_we             = 1'b1;
                wr_idx            = free_idx;
                el_wdata          = '0;
                out_d = '{stt_pkg::KIND_SCHEDULED, 3'(free_idx), stt_pkg::STATUS_OK, 1'b1};
              end else begin
                out_d = '{stt_pkg::KIND_ERROR, 3'd0, stt_pkg::STATUS_FULL, 1'b1};
              end
            end
            stt_pkg::CMD_CANCEL: begin
              out_valid_d = 1'b1;
              if (c_ok) begin
                valid_d[cidx] = 1'b0;
                out_d = '{stt_pkg::KIND_CANCELLED, fb_i.cmd.slot, stt_pkg::STATUS_OK, 1'b1};
              end else begin
                out_d = '{stt_pkg::KIND_ERROR, fb_i.cmd.slot,
                          stt_pkg::STATUS_SLOT_EMPTY, 1'b1};
              end
            end
            default: begin
              // timers held: tick-done only
              out_valid_d = 1'b1;
              out_d = '{stt_pkg::KIND_TICK_DONE, 3'd0, stt_pkg::STATUS_OK, 1'b1};
            end
          endcase
        end
      end

      // period and elapsed of idx_q are read here, valid in ST_ADD
      ST_SCAN: begin
        if (valid_q[idx_q]) begin
          state_d = ST_ADD;
        end else if (is_last_idx) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      ST_ADD: begin
        e_d     = sum[stt_pkg::ElapsedW] ? stt_pkg::ELAPSED_MAX
                                         : sum[stt_pkg::ElapsedW-1:0];
        fires_d = '0;
        state_d = ST_FIRE;
      end

      ST_FIRE: begin
        if (can_fire) begin
          e_d         = e_q - {1'b0, per_rdata};
          fires_d     = fires_q + FW'(1);
          out_valid_d = 1'b1;
          out_d = '{stt_pkg::KIND_FIRED, 3'(idx_q), stt_pkg::STATUS_OK, 1'b0};
          if (!rep_q[idx_q]) begin
            valid_d[idx_q] = 1'b0;
            state_d        = ST_WB;
          end
        end else begin
          state_d = ST_WB;
        end
      end

      ST_WB: begin
        el_we = 1'b1;
        if (is_last_idx) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + IW'(1);
          state_d = ST_SCAN;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      idx_q       <= '0;
      fires_q     <= '0;
      valid_q     <= '0;
      rep_q       <= '0;
      frm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      fires_q     <= fires_d;
      valid_q     <= valid_d;
      rep_q       <= rep_d;
      frm_q       <= frm_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    e_q     <= e_d;
    out_q   <= out_d;
  end

  assign idle_o      = (state_q == ST_IDLE) && !done_q;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

### hdl/scheduled_timer_table_top.sv
// ----------------------------------------------------------------------------
// scheduled_timer_table_top: table of periodic and one-shot timer slots
// Command intake, queue and slot executor.
// ----------------------------------------------------------------------------
// Input channel: drive cmd_i and raise start_i; the beat is taken at a rising
//   edge with start_i high and busy_o low. busy_o rises only while the
//   two-entry command queue is full. Beats with op 3 are taken and dropped.
// Result channel: res_valid_o marks each res_o beat for exactly one cycle.
//   There is no back-pressure; the receiver must take every beat. The last
//   beat of each command has res_o.last set.
// Schedule, cancel and held tick: each waits in the queue, then the idle executor
//   takes it and registers its result beat, one command per cycle while idle.
// Active tick: the executor walks every slot in order, one period/elapsed RAM
//   read per slot. An empty slot is only visited in ST_SCAN; a live slot passes
//   ST_SCAN, ST_ADD, ST_FIRE and ST_WB, with one fire beat per fire (at most
//   FIRE_LIMIT per slot; a one-shot fires at most once and is then freed). The
//   tick-done beat closes the tick.
// Reset: all slots free; the queue is emptied. Period and elapsed storage is
//   not cleared; a slot's contents are only used after a schedule writes it.
// ----------------------------------------------------------------------------
module scheduled_timer_table_top #(
  parameter int SLOTS      = 8,
  parameter int FIRE_LIMIT = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  stt_pkg::in_t  cmd_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output stt_pkg::res_t res_o
);

  stt_pkg::fb_t fb;       // head of the command queue
  logic         pop;      // executor takes the head this cycle
  logic         back_idle;

  // Front end: classify and queue commands
  stt_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .busy_o  (busy_o),
    .fb_o    (fb),
    .pop_i   (pop)
  );

  // Back end: slot table and result beats
  stt_back #(
    .SLOTS      (SLOTS),
    .FIRE_LIMIT (FIRE_LIMIT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fb_i        (fb),
    .pop_o       (pop),
    .idle_o      (back_idle),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // A full queue always has a head for the executor
  a_busy_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> fb.valid)
    else $error("busy with empty queue");

  // Empty queue stays empty unless a real command is taken
  a_queue_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!fb.valid && !(start_i && !busy_o && (cmd_i.op != stt_pkg::OP_NONE)))
      |=> !fb.valid)
    else $error("queue filled without a command");

  // Idle executor with nothing queued makes no result
  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!fb.valid && back_idle) |=> !res_valid_o)
    else $error("result beat from an idle executor");

  // A fire beat is never the closing beat of its tick
  a_fire_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.kind == stt_pkg::KIND_FIRED)) |-> !res_o.last)
    else $error("fire beat marked last");

endmodule
